@@ design/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants for the speculative tag buffer
// Queue geometry, memory widths, command and status codes, and the
// command and result transfer structs.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int THREADS       = 2;
    localparam int QUEUE_DEPTH   = 16;
    localparam int OPS_PER_ENTRY = 4;
    localparam int GRANULE_BYTES = 16;
    localparam int TAG_GRANULES  = 4096;

    localparam int TW  = $clog2(THREADS);
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int EW  = TW + QW;
    localparam int KW  = $clog2(OPS_PER_ENTRY);
    localparam int NW  = $clog2(OPS_PER_ENTRY + 1);
    localparam int OW  = EW + KW;
    localparam int GW  = $clog2(TAG_GRANULES);
    localparam int GSH = $clog2(GRANULE_BYTES);

    localparam int N_ENTRIES = THREADS * QUEUE_DEPTH;
    localparam int N_OPS     = N_ENTRIES * OPS_PER_ENTRY;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_COMMIT = 3'd3;
    localparam logic [2:0] CMD_SQUASH = 3'd4;
    localparam logic [2:0] CMD_WBACK  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_QFULL     = 2'd1;
    localparam logic [1:0] ST_OPFULL    = 2'd2;
    localparam logic [1:0] ST_UNALIGNED = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [0:0]  thread;
        logic [31:0] seq;
        logic [3:0]  slot;
        logic [15:0] byte_addr;
        logic        tag_value;
    } stb_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       tag_bit;
        logic [3:0] given_slot;
        logic [5:0] entries_removed;
    } stb_rsp_t;

    // one pending tag operation: granule and tag bit
    typedef struct packed {
        logic [GW-1:0] gran;
        logic          tag;
    } stb_op_t;

endpackage

@@ design/speculative_tag_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// speculative_tag_buffer_unit: per-thread in-order tag operation queues
// Holds pending tag set/clear operations per in-flight instruction, forwards
// lookups from the newest matching operation, and drains committed entries
// into a tag bitmap under a small sequencer.
// ----------------------------------------------------------------------------
// Insert, set, unaligned get and unknown commands finish directly; get scans the
// operations of its entry and older entries newest first, then reads the bitmap
// if none matches; commit marks entries from the head and squash removes them from
// the tail until an entry stops the walk; writeback drains retired head entries.
// One command at a time, next taken at the result edge; the receiver cannot stall.
// After reset a clearing pass zeroes all 4096 tag bitmap granules, busy high.
module speculative_tag_buffer_unit
    import stb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  stb_req_t req,
    output logic     busy,
    output logic     done,
    output stb_rsp_t rsp
);

    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_EXEC  = 14'b00000000000100,
        S_GSCAN = 14'b00000000001000,
        S_GCMP  = 14'b00000000010000,
        S_BRD   = 14'b00000000100000,
        S_BWAIT = 14'b00000001000000,
        S_CRD   = 14'b00000010000000,
        S_CCMP  = 14'b00000100000000,
        S_QRD   = 14'b00001000000000,
        S_QCMP  = 14'b00010000000000,
        S_WCHK  = 14'b00100000000000,
        S_WOP   = 14'b01000000000000,
        S_WWR   = 14'b10000000000000
    } state_t;

    // control state
    state_t               state_reg, state_next;
    logic                 done_reg, done_next;
    logic [GW-1:0]        clr_reg, clr_next;
    logic [TW-1:0]        th_reg, th_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [NW-1:0]        k_reg, k_next;
    logic [QW-1:0]        head_reg [THREADS];
    logic [QW-1:0]        head_next [THREADS];
    logic [CW-1:0]        cnt_reg [THREADS];
    logic [CW-1:0]        cnt_next [THREADS];
    logic                 retire_reg [N_ENTRIES];
    logic                 retire_next [N_ENTRIES];
    logic [NW-1:0]        opcnt_reg [N_ENTRIES];
    logic [NW-1:0]        opcnt_next [N_ENTRIES];

    // payload
    stb_req_t             req_reg, req_next;
    stb_rsp_t             rsp_reg, rsp_next;

    // memories
    logic [31:0]          seq_mem [N_ENTRIES];
    stb_op_t              op_mem [N_OPS];
    logic                 tag_mem [TAG_GRANULES];
    logic [31:0]          seq_q;
    stb_op_t              op_q;
    logic                 tag_q;

    logic                 seq_we, op_we, tag_we;
    logic [EW-1:0]        seq_wa, seq_ra;
    logic [OW-1:0]        op_wa, op_ra;
    logic [GW-1:0]        tag_wa, tag_ra;
    logic                 tag_wd;
    stb_op_t              op_wd;

    // decoded request fields
    logic [QW-1:0]        head_c;
    logic [CW-1:0]        cnt_c;
    logic [QW-1:0]        off_c;
    logic                 live_c;
    logic                 aligned_c;
    logic [GW-1:0]        gran_c;
    logic [EW-1:0]        e_slot, e_i, e_im1, e_tail, e_last, e_head;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        head_c    = head_reg[th_reg];
        cnt_c     = cnt_reg[th_reg];
        off_c     = req_reg.slot[QW-1:0] - head_c;
        live_c    = ({1'b0, off_c} < cnt_c);
        aligned_c = (req_reg.byte_addr[GSH-1:0] == '0);
        gran_c    = GW'(req_reg.byte_addr >> GSH);
        e_slot    = {th_reg, req_reg.slot[QW-1:0]};
        e_i       = {th_reg, QW'(head_c + i_reg[QW-1:0])};
        e_im1     = {th_reg, QW'(head_c + i_reg[QW-1:0] - 1'b1)};
        e_tail    = {th_reg, QW'(head_c + cnt_c[QW-1:0])};
        e_last    = {th_reg, QW'(head_c + cnt_c[QW-1:0] - 1'b1)};
        e_head    = {th_reg, head_c};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        clr_next   = clr_reg;
        th_next    = th_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        retire_next = retire_reg;
        opcnt_next = opcnt_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        seq_we = 1'b0;
        seq_wa = e_tail;
        seq_ra = e_i;
        op_we  = 1'b0;
        op_wa  = {e_slot, opcnt_reg[e_slot][KW-1:0]};
        op_wd  = '{gran: gran_c, tag: req_reg.tag_value};
        op_ra  = {e_i, KW'(k_reg - 1'b1)};
        tag_we = 1'b0;
        tag_wa = clr_reg;
        tag_wd = 1'b0;
        tag_ra = gran_c;

        case (state_reg)
            S_CLR:
            begin
                tag_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == GW'(TAG_GRANULES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    rsp_next   = '0;
                    th_next    = (req.cmd == CMD_WBACK) ? '0 : TW'(req.thread);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (req_reg.cmd)
                    CMD_INSERT:
                    begin
                        if (cnt_c == CW'(QUEUE_DEPTH))
                            rsp_next.status = ST_QFULL;
                        else
                        begin
                            seq_we = 1'b1;
                            retire_next[e_tail] = 1'b0;
                            opcnt_next[e_tail]  = '0;
                            rsp_next.given_slot = 4'(QW'(head_c + cnt_c[QW-1:0]));
                            cnt_next[th_reg]    = cnt_c + 1'b1;
                        end
                    end
                    CMD_SET:
                    begin
                        if (!aligned_c)
                            rsp_next.status = ST_UNALIGNED;
                        else if (live_c)
                        begin
                            if (opcnt_reg[e_slot] == NW'(OPS_PER_ENTRY))
                                rsp_next.status = ST_OPFULL;
                            else
                            begin
                                op_we = 1'b1;
                                opcnt_next[e_slot] = opcnt_reg[e_slot] + 1'b1;
                            end
                        end
                    end
                    CMD_GET:
                    begin
                        if (!aligned_c)
                            rsp_next.status = ST_UNALIGNED;
                        else
                        begin
                            done_next = 1'b0;
                            if (live_c)
                            begin
                                i_next     = CW'(off_c);
                                k_next     = opcnt_reg[e_slot];
                                state_next = S_GSCAN;
                            end
                            else
                                state_next = S_BRD;
                        end
                    end
                    CMD_COMMIT:
                    begin
                        done_next  = 1'b0;
                        i_next     = '0;
                        state_next = S_CRD;
                    end
                    CMD_SQUASH:
                    begin
                        done_next  = 1'b0;
                        state_next = S_QRD;
                    end
                    CMD_WBACK:
                    begin
                        done_next  = 1'b0;
                        state_next = S_WCHK;
                    end
                    default:
                    begin
                        rsp_next = '0;
                    end
                endcase
            end
            // newest-first forwarding scan
            S_GSCAN:
            begin
                if (k_reg == '0)
                begin
                    if (i_reg == '0)
                        state_next = S_BRD;
                    else
                    begin
                        i_next = i_reg - 1'b1;
                        k_next = opcnt_reg[e_im1];
                    end
                end
                else
                    state_next = S_GCMP;
            end
            S_GCMP:
            begin
                if (op_q.gran == gran_c)
                begin
                    rsp_next.tag_bit = op_q.tag;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_GSCAN;
                end
            end
            S_BRD:
            begin
                state_next = S_BWAIT;
            end
            S_BWAIT:
            begin
                rsp_next.tag_bit = tag_q;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            // commit walk from the head
            S_CRD:
            begin
                if (i_reg == cnt_c)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_CCMP;
            end
            S_CCMP:
            begin
                if (seq_q > req_reg.seq)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    retire_next[e_i] = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            // squash walk from the tail
            S_QRD:
            begin
                seq_ra = e_last;
                if (cnt_c == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_QCMP;
            end
            S_QCMP:
            begin
                if (seq_q <= req_reg.seq)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    opcnt_next[e_last]  = '0;
                    retire_next[e_last] = 1'b0;
                    cnt_next[th_reg]    = cnt_c - 1'b1;
                    rsp_next.entries_removed = rsp_reg.entries_removed + 1'b1;
                    state_next = S_QRD;
                end
            end
            // writeback: drain retirable head entries of each thread
            S_WCHK:
            begin
                if (cnt_c != '0 && retire_reg[e_head])
                begin
                    k_next     = '0;
                    state_next = S_WOP;
                end
                else if (th_reg == TW'(THREADS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    th_next = th_reg + 1'b1;
            end
            S_WOP:
            begin
                op_ra = {e_head, k_reg[KW-1:0]};
                if (k_reg == opcnt_reg[e_head])
                begin
                    opcnt_next[e_head]  = '0;
                    retire_next[e_head] = 1'b0;
                    head_next[th_reg]   = head_c + 1'b1;
                    cnt_next[th_reg]    = cnt_c - 1'b1;
                    rsp_next.entries_removed = rsp_reg.entries_removed + 1'b1;
                    state_next = S_WCHK;
                end
                else
                    state_next = S_WWR;
            end
            S_WWR:
            begin
                tag_we     = 1'b1;
                tag_wa     = op_q.gran;
                tag_wd     = op_q.tag;
                k_next     = k_reg + 1'b1;
                state_next = S_WOP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            done_reg  <= 1'b0;
            clr_reg   <= '0;
            th_reg    <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            for (int t = 0; t < THREADS; t++)
            begin
                head_reg[t] <= '0;
                cnt_reg[t]  <= '0;
            end
            for (int e = 0; e < N_ENTRIES; e++)
            begin
                retire_reg[e] <= 1'b0;
                opcnt_reg[e]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            clr_reg    <= clr_next;
            th_reg     <= th_next;
            i_reg      <= i_next;
            k_reg      <= k_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            retire_reg <= retire_next;
            opcnt_reg  <= opcnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // sequence number memory
    always_ff @(posedge clk)
    begin
        if (seq_we)
            seq_mem[seq_wa] <= req_reg.seq;
        seq_q <= seq_mem[seq_ra];
    end

    // tag operation memory
    always_ff @(posedge clk)
    begin
        if (op_we)
            op_mem[op_wa] <= op_wd;
        op_q <= op_mem[op_ra];
    end

    // committed tag bitmap
    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_wa] <= tag_wd;
        tag_q <= tag_mem[tag_ra];
    end

endmodule
